>>> hw/rtl/pmf_pkg.sv
// Package for the probability mass table sampler.
// Holds the item codes, register indexes and the payload structs of both directions.
// No dependencies.
package pmf_pkg;

    localparam int unsigned PROB_W  = 33;
    localparam int unsigned FRAC_W  = 32;
    localparam int unsigned SUM_W   = 34;
    localparam int unsigned OFFS_W  = 32;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned EIDX_W  = 10;
    localparam int unsigned RES_W   = 33;
    localparam int unsigned CFG_A_W = 2;
    localparam int unsigned CFG_D_W = 32;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_LOAD     = 2'd0;
    localparam t_kind KIND_SAMPLE   = 2'd1;
    localparam t_kind KIND_QUANTILE = 2'd2;

    typedef logic [CFG_A_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_VALUE_OFFSET = 2'd0;
    localparam t_cfg_index CFG_TABLE_LENGTH = 2'd1;

    typedef struct packed {
        t_kind              kind;
        logic [EIDX_W-1:0]  entry_index;
        logic [PROB_W-1:0]  entry_probability;
        logic [FRAC_W-1:0]  uniform_fraction;
        logic [PROB_W-1:0]  quantile_level;
    } t_item;

    typedef struct packed {
        logic signed [RES_W-1:0] result_value;
        logic                    ran_off_end;
    } t_result;

endpackage

>>> hw/rtl/pmf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pmf_ram #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/pmf_inverse_cdf_sampler.sv
// Top level of the discrete inverse-transform sampler over a probability mass table.
// Depends on pmf_pkg (types, codes) and pmf_ram (the table memory).
//
// A load transaction writes one table entry at its accepting edge and leaves busy low, so
// loads can be issued back to back. A sample or quantile transaction raises busy and
// walks the table from index zero, reading one entry per cycle through the single read
// port of the table RAM and adding it into an exact 34-bit running sum; that one read,
// add and compare per cycle sets the pace. A query walks at most the used length
// of the table (table_length held between one and DEPTH), never more than DEPTH
// entries; busy falls in the cycle the result strobe is high. The result is presented
// on o_result for exactly one cycle with o_result_valid high and the receiver must
// take it then, as there is no way to hold it off. Configuration writes are always
// accepted and should be issued only while the block is idle. Table entries have no
// reset value: every entry a query can reach must have been loaded first.
module pmf_inverse_cdf_sampler #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  pmf_pkg::t_item                      i_item,
    output logic                                o_result_valid,
    output pmf_pkg::t_result                    o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  pmf_pkg::t_cfg_index                 i_cfg_index,
    input  logic [pmf_pkg::CFG_D_W-1:0]         i_cfg_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Sequencer state codes.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    // Configuration registers.
    logic [pmf_pkg::OFFS_W-1:0] r_value_offset;
    logic [pmf_pkg::LEN_W-1:0]  r_table_length;

    // Sequencer and datapath registers.
    logic                        r_state, n_state;
    logic [AW-1:0]               r_idx, n_idx;
    logic [AW-1:0]               r_last, n_last;
    logic [pmf_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [pmf_pkg::PROB_W-1:0]  r_thr, n_thr;
    logic                        r_is_sample, n_is_sample;
    logic                        r_result_valid, n_result_valid;
    pmf_pkg::t_result            r_result, n_result;

    logic                        accept;
    logic                        is_query;
    logic [AW-1:0]               last_entry;
    logic                        load_in_range;
    logic                        ram_we;
    logic [AW-1:0]               ram_raddr;
    logic [pmf_pkg::PROB_W-1:0]  ram_rdata;
    logic [pmf_pkg::SUM_W-1:0]   acc_sum;
    logic                        acc_hit;
    logic [AW:0]                 pick;
    logic signed [pmf_pkg::RES_W-1:0] offset_ext;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign is_query = (i_item.kind == pmf_pkg::KIND_SAMPLE) ||
                      (i_item.kind == pmf_pkg::KIND_QUANTILE);

    // Last index in use: the length register saturates into the range one to DEPTH.
    always_comb begin
        priority if (r_table_length == '0) begin
            last_entry = '0;
        end else if (32'(r_table_length) > 32'(DEPTH)) begin
            last_entry = AW'(DEPTH - 1);
        end else begin
            last_entry = AW'(r_table_length - 1'b1);
        end
    end

    // Loads that point past the end of the table are dropped.
    assign load_in_range = (32'(i_item.entry_index) < 32'(DEPTH));
    assign ram_we = accept && (i_item.kind == pmf_pkg::KIND_LOAD) && load_in_range;

    // While idle the RAM is primed with entry zero, so the walk starts on the cycle
    // after acceptance; during the walk it fetches the entry after the one being summed.
    assign ram_raddr = (r_state == ST_IDLE) ? '0 : r_idx + 1'b1;

    pmf_ram #(
        .WIDTH (pmf_pkg::PROB_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_item.entry_index)),
        .i_wdata (i_item.entry_probability),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The running sum never exceeds the threshold before the final add, so 34 bits
    // keep it exact.
    assign acc_sum = r_sum + {1'b0, ram_rdata};
    assign acc_hit = acc_sum > {1'b0, r_thr};

    assign offset_ext = pmf_pkg::RES_W'($signed(r_value_offset));

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_last         = r_last;
        n_sum          = r_sum;
        n_thr          = r_thr;
        n_is_sample    = r_is_sample;
        n_result_valid = 1'b0;
        n_result       = r_result;
        pick           = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept && is_query) begin
                    n_state     = ST_WALK;
                    n_idx       = '0;
                    n_last      = last_entry;
                    n_sum       = '0;
                    n_is_sample = (i_item.kind == pmf_pkg::KIND_SAMPLE);
                    n_thr       = (i_item.kind == pmf_pkg::KIND_SAMPLE) ?
                                  {1'b0, i_item.uniform_fraction} : i_item.quantile_level;
                end
            end
            ST_WALK: begin
                n_sum = acc_sum;
                n_idx = r_idx + 1'b1;
                if (acc_hit || (r_idx == r_last)) begin
                    // A sample that runs off the end reports the last entry, a quantile
                    // query reports one past it.
                    if (acc_hit || r_is_sample) begin
                        pick = {1'b0, r_idx};
                    end else begin
                        pick = {1'b0, r_idx} + 1'b1;
                    end
                    n_state                  = ST_IDLE;
                    n_result_valid           = 1'b1;
                    n_result.ran_off_end     = !acc_hit;
                    n_result.result_value    = offset_ext +
                                               $signed(pmf_pkg::RES_W'(pick));
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_result_valid <= 1'b0;
            r_value_offset <= '0;
            r_table_length <= pmf_pkg::LEN_W'(1);
        end else begin
            r_state        <= n_state;
            r_result_valid <= n_result_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    pmf_pkg::CFG_VALUE_OFFSET: r_value_offset <= i_cfg_data;
                    pmf_pkg::CFG_TABLE_LENGTH:
                        r_table_length <= i_cfg_data[pmf_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_last      <= n_last;
        r_sum       <= n_sum;
        r_thr       <= n_thr;
        r_is_sample <= n_is_sample;
        r_result    <= n_result;
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

>>> dv/tb_pmf_inverse_cdf_sampler.sv
// Self-checking testbench for the probability mass table sampler (pmf_inverse_cdf_sampler).
// Depends on pmf_pkg for the item, result and register types and codes; drives the block
// through its start/busy command port and its register channel, predicts every draw itself.
module tb_pmf_inverse_cdf_sampler;

    localparam int unsigned DEPTH = 1024;

    // A query walks at most DEPTH entries, so a stretch of this many cycles with no
    // transaction of any kind means the block has hung.
    localparam int unsigned STALL_LIMIT = 10000;

    // Number of leading table entries loaded while the length is saturated at DEPTH.
    localparam int unsigned PREFIX_LEN = 96;

    // The block ignores the fourth item code; it has no name in the package.
    localparam pmf_pkg::t_kind KIND_UNUSED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    pmf_pkg::t_item       i_item = '0;
    logic                 o_result_valid;
    pmf_pkg::t_result     o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    pmf_pkg::t_cfg_index  i_cfg_index = pmf_pkg::CFG_VALUE_OFFSET;
    logic [31:0]          i_cfg_data = '0;

    pmf_inverse_cdf_sampler #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Items waiting to be offered, and the draws predicted for accepted queries.
    pmf_pkg::t_item   pending_items[$];
    pmf_pkg::t_result expected_draws[$];

    // The predictor's own copy of the table and the two registers.
    logic [32:0] model_pmf [DEPTH];
    logic [31:0] model_offset = '0;
    logic [10:0] model_len = 11'd1;

    // The stimulus side keeps a second copy of the table so that it can aim query
    // thresholds right at the running sums, where the walk changes its answer.
    logic [32:0] gen_pmf [DEPTH];
    int unsigned gen_len = 1;
    int unsigned sender_idle_pct = 0;

    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;

    task automatic note_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // Applies one accepted transaction to the predictor. A load updates the table, a
    // sample or quantile query walks the used part of the table with an exact running
    // sum and queues the draw it must produce, and the unused code changes nothing.
    function automatic void predict_draw(input pmf_pkg::t_item it);
        logic [39:0] run;
        logic [32:0] thr;
        int unsigned n;
        int unsigned k;
        int unsigned pick;
        bit          hit;
        pmf_pkg::t_result draw;
        if (it.kind == pmf_pkg::KIND_LOAD) begin
            model_pmf[it.entry_index] = it.entry_probability;
            return;
        end
        if (it.kind != pmf_pkg::KIND_SAMPLE && it.kind != pmf_pkg::KIND_QUANTILE) begin
            return;
        end
        // The length register saturates into 1..DEPTH.
        n = model_len;
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        thr = (it.kind == pmf_pkg::KIND_SAMPLE) ? {1'b0, it.uniform_fraction}
                                                : it.quantile_level;
        run = '0;
        k = 0;
        hit = 1'b0;
        while (k < n && !hit) begin
            run = run + 40'(model_pmf[k]);
            if (run > 40'(thr)) begin
                hit = 1'b1;
            end else begin
                k++;
            end
        end
        // Running off the end gives the last value for a sample, one past it for a quantile.
        pick = k;
        if (!hit && it.kind == pmf_pkg::KIND_SAMPLE) pick = n - 1;
        draw.ran_off_end = !hit;
        draw.result_value = {model_offset[31], model_offset} + 33'(pick);
        expected_draws.insert(expected_draws.size(), draw);
    endfunction

    // Driver. An item is taken at an edge where start is high and busy is low. While busy
    // is high the offered item is held as it is; otherwise the next item is offered unless
    // the sender chooses to idle this cycle. Register writes are mirrored into the
    // predictor at the edge that completes them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pmf_pkg::CFG_VALUE_OFFSET: model_offset = i_cfg_data;
                    pmf_pkg::CFG_TABLE_LENGTH: model_len = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                predict_draw(i_item);
            end
            if (start && busy) begin
                // Keep offering the same transaction until the block takes it.
            end else if (pending_items.size() != 0 &&
                         $urandom_range(99) >= sender_idle_pct) begin
                i_item <= pending_items.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor. A result is valid for exactly one cycle and is taken at the edge that ends it.
    always @(posedge i_clk) begin
        pmf_pkg::t_result want;
        if (i_rst_n && o_result_valid) begin
            if (expected_draws.size() == 0) begin
                note_mismatch($sformatf("draw value=%0d off_end=%0b with no query pending",
                                        o_result.result_value, o_result.ran_off_end));
            end else begin
                want = expected_draws.pop_front();
                if (o_result.result_value !== want.result_value) begin
                    note_mismatch($sformatf("result_value got %0d expected %0d",
                                            o_result.result_value, want.result_value));
                end
                if (o_result.ran_off_end !== want.ran_off_end) begin
                    note_mismatch($sformatf("ran_off_end got %0b expected %0b",
                                            o_result.ran_off_end, want.ran_off_end));
                end
            end
        end
    end

    // Watchdog. Any accepted item, result or register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Every item starts out with random bits in all fields, so the fields that its kind
    // does not use still toggle; the fields it does use are then set on top.
    function automatic pmf_pkg::t_item noise_item();
        pmf_pkg::t_item it;
        it.kind = pmf_pkg::t_kind'($urandom_range(3));
        it.entry_index = 10'($urandom);
        it.entry_probability = {1'($urandom_range(1)), $urandom};
        it.uniform_fraction = $urandom;
        it.quantile_level = {1'($urandom_range(1)), $urandom};
        return it;
    endfunction

    task automatic push_load(input logic [9:0] idx, input logic [32:0] prob);
        pmf_pkg::t_item it;
        it = noise_item();
        it.kind = pmf_pkg::KIND_LOAD;
        it.entry_index = idx;
        it.entry_probability = prob;
        gen_pmf[idx] = prob;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_sample(input logic [31:0] frac);
        pmf_pkg::t_item it;
        it = noise_item();
        it.kind = pmf_pkg::KIND_SAMPLE;
        it.uniform_fraction = frac;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_quantile(input logic [32:0] level);
        pmf_pkg::t_item it;
        it = noise_item();
        it.kind = pmf_pkg::KIND_QUANTILE;
        it.quantile_level = level;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_unused();
        pmf_pkg::t_item it;
        it = noise_item();
        it.kind = KIND_UNUSED;
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic logic [39:0] prefix_sum(input int unsigned last);
        logic [39:0] acc;
        acc = '0;
        for (int unsigned k = 0; k <= last; k++) begin
            acc = acc + 40'(gen_pmf[k]);
        end
        return acc;
    endfunction

    // Probabilities are scaled to the table length so that the running sum tends to
    // cross the range of thresholds; some are zero, exactly one, or any 33-bit value.
    function automatic logic [32:0] pick_probability();
        longint unsigned bound;
        case ($urandom_range(9))
            0: return '0;
            1: return 33'h1_0000_0000;
            2: return {1'($urandom_range(1)), $urandom};
            default: begin
                bound = (64'hFFFF_FFFF / gen_len) * 2;
                if (bound > 64'hFFFF_FFFF) bound = 64'hFFFF_FFFF;
                return 33'($urandom_range(32'(bound)));
            end
        endcase
    endfunction

    // Half of the thresholds are placed on a running sum or one off it, so that both sides of
    // the strict comparison are hit; the rest are field extremes or fully random.
    function automatic logic [32:0] pick_threshold(input bit quantile);
        logic [39:0] thr;
        logic [39:0] cap;
        cap = quantile ? 40'h1_FFFF_FFFF : 40'hFFFF_FFFF;
        case ($urandom_range(9))
            0: thr = '0;
            1: thr = quantile ? 40'h1_0000_0000 : 40'hFFFF_FFFF;
            2: thr = cap;
            3, 4, 5, 6, 7: begin
                thr = prefix_sum($urandom_range(gen_len - 1));
                case ($urandom_range(2))
                    0: if (thr != 0) thr = thr - 1;
                    2: thr = thr + 1;
                    default: ;
                endcase
            end
            default: thr = quantile ? 40'({1'($urandom_range(1)), $urandom}) : 40'($urandom);
        endcase
        if (thr > cap) thr = cap;
        return thr[32:0];
    endfunction

    task automatic push_random_items(input int unsigned count);
        int unsigned r;
        logic [9:0]  idx;
        for (int unsigned i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 30) begin
                idx = ($urandom_range(4) != 0) ? 10'($urandom_range(gen_len - 1))
                                                : 10'($urandom_range(DEPTH - 1));
                push_load(idx, pick_probability());
            end else if (r < 62) begin
                push_sample(32'(pick_threshold(1'b0)));
            end else if (r < 95) begin
                push_quantile(pick_threshold(1'b1));
            end else begin
                push_unused();
            end
        end
    endtask

    // Waits until every queued item has been taken and every predicted draw has come
    // back. The check is made at the falling edge, when all signals have settled. Loads
    // never raise busy, so the pause after that leaves the block idle.
    task automatic drain();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || start || expected_draws.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input pmf_pkg::t_cfg_index idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Starts a new phase: both registers are rewritten while the block is idle. The
    // length goes out with random upper bits, which the block must drop.
    task automatic set_phase(input logic [31:0] offset, input logic [10:0] raw_len,
                             input int unsigned idle_pct);
        logic [31:0] len_word;
        drain();
        len_word = (($urandom() >> 11) << 11) | 32'(raw_len);
        write_reg(pmf_pkg::CFG_VALUE_OFFSET, offset);
        write_reg(pmf_pkg::CFG_TABLE_LENGTH, len_word);
        gen_len = (raw_len == 0) ? 1 : ((raw_len > DEPTH) ? DEPTH : raw_len);
        sender_idle_pct = idle_pct;
    endtask

    initial begin
        logic [31:0] offset;
        logic [10:0] raw_len;
        logic [32:0] prob;
        int unsigned idle_modes [3];
        idle_modes[0] = 0;
        idle_modes[1] = 63;
        idle_modes[2] = 29;
        for (int unsigned k = 0; k < DEPTH; k++) begin
            model_pmf[k] = '0;
            gen_pmf[k] = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the reset settings: length one, offset zero. Only entry
        // zero is ever walked here, and it is loaded before the first query.
        push_unused();
        push_load(10'd0, 33'h1_0000_0000);
        push_sample(32'h0000_0000);
        push_sample(32'hFFFF_FFFF);
        push_quantile(33'h1_0000_0000);     // sum equals the level: runs off the end
        push_quantile(33'h0_0000_0000);
        push_quantile(33'h1_FFFF_FFFF);
        push_load(10'd0, 33'h0_0000_0000);  // an all-zero table: both kinds run off
        push_sample(32'h0000_0000);
        push_quantile(33'h0_0000_0000);
        push_load(10'd0, 33'h1_FFFF_FFFF);  // an entry above one is kept as given
        push_quantile(33'h1_FFFF_FFFF - 33'd1);
        push_quantile(33'h1_FFFF_FFFF);
        push_load(10'd1023, 33'h1_FFFF_FFFF);
        push_load(10'd0, 33'h0_0000_0001);
        push_sample(32'h0000_0000);
        push_sample(32'h0000_0001);
        push_unused();

        // A length beyond DEPTH saturates down to DEPTH. Only a leading block of entries
        // is loaded: small values first, then two entries of the largest size, so that
        // every walk is stopped inside the loaded block whatever its threshold. From
        // here on no query can reach an entry that was never written.
        set_phase(32'h7FFF_FFFF, 11'd2047, 29);
        for (int unsigned k = 0; k < PREFIX_LEN; k++) begin
            if (k >= PREFIX_LEN - 2) begin
                prob = 33'h1_FFFF_FFFF;
            end else if ($urandom_range(7) == 0) begin
                prob = '0;
            end else begin
                prob = 33'($urandom_range(32'h3F_FFFF));
            end
            push_load(10'(k), prob);
        end
        push_sample(32'hFFFF_FFFF);
        push_quantile(33'h1_0000_0000);
        push_sample(32'h0000_0000);
        push_quantile(33'(prefix_sum($urandom_range(PREFIX_LEN - 1))));
        push_sample(32'(pick_threshold(1'b0)));
        push_quantile(33'h1_FFFF_FFFF);

        // The small entries alone never reach the two top thresholds below, so both kinds run
        // off the end there at the largest offset and the value passes the 32-bit range.
        set_phase(32'h7FFF_FFFF, 11'd80, 0);
        push_sample(32'hFFFF_FFFF);
        push_quantile(33'h1_FFFF_FFFF);
        push_sample(32'h0000_0000);

        // A length of zero saturates up to one, at the most negative offset.
        set_phase(32'h8000_0000, 11'd0, 63);
        push_sample(32'hFFFF_FFFF);
        push_quantile(33'h1_FFFF_FFFF);
        push_random_items(18);

        // Random phases, mostly short tables so that each walk stays brief.
        for (int unsigned p = 0; p < 8; p++) begin
            case ($urandom_range(4))
                0: offset = 32'h0000_0000;
                1: offset = 32'h7FFF_FFFF;
                2: offset = 32'h8000_0000;
                default: offset = $urandom;
            endcase
            case ($urandom_range(7))
                0: raw_len = 11'd0;
                1: raw_len = 11'($urandom_range(17, 80));
                default: raw_len = 11'($urandom_range(1, 16));
            endcase
            set_phase(offset, raw_len, idle_modes[p % 3]);
            push_random_items(55);
        end

        drain();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> pmf_inverse_cdf_sampler.f
hw/rtl/pmf_pkg.sv
hw/rtl/pmf_ram.sv
hw/rtl/pmf_inverse_cdf_sampler.sv
dv/tb_pmf_inverse_cdf_sampler.sv
